FILE: sv/sxt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character classes of the S-expression tokenizer.
// No dependencies; every other file but sxt_if imports this package.
package sxt_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int WIDE_W       = 33;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7c;

  typedef enum logic [2:0] {
    TT_OPEN   = 3'd0,
    TT_CLOSE  = 3'd1,
    TT_INT    = 3'd2,
    TT_STR    = 3'd3,
    TT_SYMBOL = 3'd4
  } tok_type_t;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_NUM     = 5'b00010,
    MODE_IDENT   = 5'b00100,
    MODE_STR     = 5'b01000,
    MODE_COMMENT = 5'b10000
  } lex_mode_t;

  typedef struct packed {
    tok_type_t   tok_type;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           is_digit(c) || (c == CH_UNDER) || (c == CH_MINUS) || (c == CH_PLUS) ||
           (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PCT) || (c == CH_CARET) ||
           (c == CH_AMP) || (c == CH_BAR) || (c == CH_TILDE);
  endfunction

  function automatic logic [15:0] sat16(logic [WIDE_W-1:0] v);
    return (v > WIDE_W'(16'hffff)) ? 16'hffff : v[15:0];
  endfunction

endpackage

FILE: sv/sxt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for characters in and tokens out.
// No dependencies.
interface sxt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_char;
  modport source (output valid, output ch, output last_char, input ready);
  modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface sxt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  tok_type;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic        last_of_run;
  modport source (output valid, output tok_type, output tok_start, output tok_len,
                  output last_of_run, input ready);
  modport sink   (input valid, input tok_type, input tok_start, input tok_len,
                  input last_of_run, output ready);
endinterface

FILE: sv/sxt_front.sv
`timescale 1ns / 1ps
// Front end: lexer mode, token start and position counter; classifies one
// character per transaction into zero to two tokens. Depends on sxt_pkg.
module sxt_front import sxt_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       last_char,
  output logic       push,
  output job_t       job
);

  lex_mode_t           mode_r, mode_nxt;
  logic [POS_BITS-1:0] begin_r, begin_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;

  logic [POS_BITS-1:0] p_next;
  logic [POS_BITS:0]   p_w, p1_w;
  logic                dig, idc, fresh;
  logic [1:0]          n;
  token_t              t0, t1;

  function automatic token_t mk_tok(tok_type_t t, logic [POS_BITS:0] s,
                                    logic [POS_BITS:0] e);
    token_t r;
    r.tok_type  = t;
    r.tok_start = sat16(WIDE_W'(s));
    r.tok_len   = (e >= s) ? sat16(WIDE_W'(e - s)) : 16'd0;
    return r;
  endfunction

  always_comb begin
    dig    = is_digit(ch);
    idc    = is_ident(ch);
    p_w    = (POS_BITS+1)'(pos_r);
    p1_w   = p_w + (POS_BITS+1)'(1);
    p_next = (&pos_r) ? pos_r : pos_r + POS_BITS'(1);
    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    fresh = 1'b0;
    n  = 2'd0;
    t0 = '0;
    t1 = '0;

    unique case (mode_r)
      MODE_NUM: begin
        if (!dig) begin
          t0 = mk_tok(TT_INT, (POS_BITS+1)'(begin_r), p_w);
          n = 2'd1;
          mode_nxt = MODE_IDLE;
          fresh = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!idc) begin
          t0 = mk_tok(TT_SYMBOL, (POS_BITS+1)'(begin_r), p_w);
          n = 2'd1;
          mode_nxt = MODE_IDLE;
          fresh = 1'b1;
        end
      end
      MODE_STR: begin
        if (ch == CH_QUOTE) begin
          t0 = mk_tok(TT_STR, (POS_BITS+1)'(begin_r), p_w);
          n = 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_COMMENT: begin
        if (ch == CH_NL) mode_nxt = MODE_IDLE;
      end
      default: begin
        mode_nxt = MODE_IDLE;
        fresh = 1'b1;
      end
    endcase

    if (fresh) begin
      priority if (ch == CH_LPAREN || ch == CH_RPAREN) begin
        if (n == 2'd0) t0 = mk_tok((ch == CH_LPAREN) ? TT_OPEN : TT_CLOSE, p_w, p1_w);
        else t1 = mk_tok((ch == CH_LPAREN) ? TT_OPEN : TT_CLOSE, p_w, p1_w);
        n = n + 2'd1;
      end else if (ch == CH_QUOTE) begin
        mode_nxt  = MODE_STR;
        begin_nxt = p_next;
      end else if (ch == CH_SEMI) begin
        mode_nxt = MODE_COMMENT;
      end else if (dig) begin
        mode_nxt  = MODE_NUM;
        begin_nxt = pos_r;
      end else if (idc) begin
        mode_nxt  = MODE_IDENT;
        begin_nxt = pos_r;
      end else begin
        mode_nxt = MODE_IDLE;
      end
    end

    if (last_char) begin
      if (mode_nxt == MODE_NUM || mode_nxt == MODE_IDENT) begin
        if (n == 2'd0)
          t0 = mk_tok((mode_nxt == MODE_NUM) ? TT_INT : TT_SYMBOL,
                      (POS_BITS+1)'(begin_nxt), p1_w);
        else
          t1 = mk_tok((mode_nxt == MODE_NUM) ? TT_INT : TT_SYMBOL,
                      (POS_BITS+1)'(begin_nxt), p1_w);
        n = n + 2'd1;
      end
      mode_nxt  = MODE_IDLE;
      begin_nxt = '0;
      pos_nxt   = '0;
    end else begin
      pos_nxt = p_next;
    end
  end

  assign push     = accept && (n != 2'd0);
  assign job.two  = n[1];
  assign job.tok0 = t0;
  assign job.tok1 = t1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      begin_r <= '0;
      pos_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

FILE: sv/sxt_queue.sv
`timescale 1ns / 1ps
// Short token-job queue between front and back end.
// Depends on sxt_pkg.
module sxt_queue import sxt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;

  assign status.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign head = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop) rd_r <= rd_r + QPTR_W'(1);
      if (push && !pop) cnt_r <= cnt_r + (QPTR_W+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (QPTR_W+1)'(1);
    end
  end

endmodule

FILE: sv/sxt_back.sv
`timescale 1ns / 1ps
// Back end: serialises each queued job into one or two token transactions
// through an output register. Depends on sxt_pkg and sxt_out_if.
module sxt_back import sxt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  q_status_t status,
  output logic      pop,
  sxt_out_if.source out_chan
);

  logic   valid_r;
  logic   sel_r;
  token_t tok_r;
  logic   last_r;
  logic   load, is_last;

  assign load    = (!valid_r || out_chan.ready) && !status.empty;
  assign is_last = sel_r || !head.two;
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      sel_r   <= !is_last;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= sel_r ? head.tok1 : head.tok0;
      last_r <= is_last;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.tok_type    = tok_r.tok_type;
  assign out_chan.tok_start   = tok_r.tok_start;
  assign out_chan.tok_len     = tok_r.tok_len;
  assign out_chan.last_of_run = last_r;

endmodule

FILE: sv/s_expression_tokenizer.sv
`timescale 1ns / 1ps
// S-expression tokenizer: characters in, (type, start, length) tokens out.
// Depends on sxt_pkg, sxt_if, sxt_front, sxt_queue and sxt_back.
//
// One character is taken per cycle whenever the four-entry job queue has
// room, even while a token waits at the output. The front end classifies
// the character in that same cycle; a character that ends a pending token
// and is itself a parenthesis, or that ends one token and starts another as
// the last of the text, yields two tokens. The
// back end sends one token per cycle from its output register while the
// output is ready, so the sustained rate is one character per cycle as long
// as the text averages at most one token per character; a run of two-token
// characters drains as two output transactions each and fills the queue.
// There is no clearing pass after reset.
module s_expression_tokenizer import sxt_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sxt_in_if.sink    in_chan,
  sxt_out_if.source out_chan
);

  logic      accept, push, pop;
  job_t      job, head;
  q_status_t status;

  assign in_chan.ready = !status.full;
  assign accept = in_chan.valid && !status.full;

  sxt_front #(.POS_BITS(POS_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ch        (in_chan.ch),
    .last_char (in_chan.last_char),
    .push      (push),
    .job       (job)
  );

  sxt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  sxt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .status   (status),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

FILE: sv/sxt_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the tokenizer, bound to the top level.
// Depends on sxt_pkg and s_expression_tokenizer.
module sxt_checker import sxt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  tok_type,
  input logic [15:0] tok_len
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("token transaction withdrawn while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token shown straight after reset");

  a_paren_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (tok_type == TT_OPEN || tok_type == TT_CLOSE) |-> tok_len == 16'd1)
    else $error("parenthesis token with length other than one");

  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input held off while no token is on offer");

endmodule

bind s_expression_tokenizer sxt_checker u_sxt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .tok_type  (out_chan.tok_type),
  .tok_len   (out_chan.tok_len)
);
